/* sv/assert_macros.svh */
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* sv/itp_pkg.sv */
// Types, character codes and operator helpers for the infix-to-postfix converter.
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  // ASCII characters the converter recognizes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_TIMES  = 8'h2A;
  localparam logic [7:0] CH_DIVIDE = 8'h2F;
  localparam logic [7:0] CH_TERM   = 8'h00;

  // Operator codes as held on the stack
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LPAREN = 3'd1,
    OP_PLUS   = 3'd2,
    OP_MINUS  = 3'd3,
    OP_TIMES  = 3'd4,
    OP_DIVIDE = 3'd5
  } op_code_t;

  // Request class decided by the front end
  typedef enum logic [2:0] {
    KIND_IGNORE = 3'd0,
    KIND_DIGIT  = 3'd1,
    KIND_LPAREN = 3'd2,
    KIND_OPER   = 3'd3,
    KIND_RPAREN = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    op_code_t   code;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  typedef enum logic {
    ST_MAIN  = 1'b0,
    ST_FLUSH = 1'b1
  } back_state_t;

  // Precedence: '(' lowest so an operator never pops it
  function automatic logic [1:0] op_prec(input op_code_t c);
    logic [1:0] p;
    p = 2'd0;
    case (c) inside
      OP_TIMES, OP_DIVIDE: p = 2'd2;
      OP_PLUS, OP_MINUS:   p = 2'd1;
      default:             p = 2'd0;
    endcase
    return p;
  endfunction

  // Character emitted for a stacked code
  function automatic logic [7:0] op_char(input op_code_t c);
    logic [7:0] ch;
    ch = CH_TERM;
    case (c)
      OP_LPAREN: ch = CH_LPAREN;
      OP_PLUS:   ch = CH_PLUS;
      OP_MINUS:  ch = CH_MINUS;
      OP_TIMES:  ch = CH_TIMES;
      OP_DIVIDE: ch = CH_DIVIDE;
      default:   ch = CH_TERM;
    endcase
    return ch;
  endfunction

endpackage

/* sv/itp_ram.sv */
// Generic single-write, single-read RAM with registered, write-first read.
module itp_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, and return fresh data on a same-address read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/itp_front.sv */
// Front end: accepts input characters, classifies them and registers the request.
module itp_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_char,
  input  logic         in_expr_last,
  output itp_pkg::cmd_t cmd,
  output logic         cmd_valid,
  input  logic         cmd_ready
);
  import itp_pkg::*;

  cmd_t cls;
  cmd_t cmd_r, cmd_nxt;
  logic vld_r, vld_nxt;
  logic keep;

  // Classify the incoming character
  always_comb begin
    cls.ch   = in_char;
    cls.last = in_expr_last;
    cls.code = OP_NONE;
    cls.kind = KIND_IGNORE;
    if ((in_char >= CH_ZERO) && (in_char <= CH_NINE)) begin
      cls.kind = KIND_DIGIT;
    end else begin
      unique case (in_char)
        CH_LPAREN: cls.kind = KIND_LPAREN;
        CH_RPAREN: cls.kind = KIND_RPAREN;
        CH_PLUS: begin
          cls.kind = KIND_OPER;
          cls.code = OP_PLUS;
        end
        CH_MINUS: begin
          cls.kind = KIND_OPER;
          cls.code = OP_MINUS;
        end
        CH_TIMES: begin
          cls.kind = KIND_OPER;
          cls.code = OP_TIMES;
        end
        CH_DIVIDE: begin
          cls.kind = KIND_OPER;
          cls.code = OP_DIVIDE;
        end
        default: cls.kind = KIND_IGNORE;
      endcase
    end
  end

  // Drop ignored characters unless they close the expression
  assign keep     = (cls.kind != KIND_IGNORE) || in_expr_last;
  assign in_ready = !vld_r || cmd_ready;

  always_comb begin
    vld_nxt = vld_r;
    cmd_nxt = cmd_r;
    if (cmd_ready) begin
      vld_nxt = 1'b0;
    end
    if (in_valid && in_ready && keep) begin
      vld_nxt = 1'b1;
      cmd_nxt = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd       = cmd_r;
  assign cmd_valid = vld_r;

endmodule

/* sv/itp_queue.sv */
// Two-entry request queue between the front end and the stack sequencer.
`include "assert_macros.svh"
module itp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  itp_pkg::cmd_t wr_cmd,
  input  logic          wr_valid,
  output logic          wr_ready,
  output itp_pkg::cmd_t rd_cmd,
  output logic          rd_valid,
  input  logic          rd_ready
);
  import itp_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       wr_en, rd_en;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_en ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  `ASSERT_NEVER(a_q_overrun, clk, rst_n, wr_en && (count_r == 2'd2), "queue write while full")
  `ASSERT_AT(a_q_ptrs, clk, rst_n, (count_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r), "queue pointers disagree when empty")

endmodule

/* sv/itp_back.sv */
// Back end: operator stack sequencer that pops, pushes and emits postfix characters.
`include "assert_macros.svh"
module itp_back #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  itp_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_run_last,
  output logic          out_expr_end,
  output logic          out_overflow
);
  import itp_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int RAM_DEPTH = 1 << AW;
  localparam logic [AW-1:0] CNT_MAX = AW'(STACK_DEPTH - 1);
  localparam logic [AW-1:0] CNT_ONE = AW'(1);
  localparam logic [AW-1:0] CNT_TWO = AW'(2);

  back_state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  op_code_t top_r, top_nxt;
  logic ov_r, ov_nxt;

  // Stack memory below the top entry
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [2:0]    rdata;
  op_code_t      below;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_run_last_r, out_expr_end_r, out_overflow_r;

  logic       can_emit, has_top, below_ok;
  logic       emit, emit_run, emit_end;
  logic [7:0] emit_char;
  logic       do_push, do_pop, item_done;
  op_code_t   push_code;

  assign below    = op_code_t'(rdata);
  assign can_emit = !out_valid_r || out_ready;
  assign has_top  = (cnt_r != '0);
  assign below_ok = (cnt_r > CNT_ONE);

  // Sequence one action per cycle on the request at the queue head; an emitting action waits while the output is held
  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    emit_run  = 1'b0;
    emit_end  = 1'b0;
    emit_char = CH_TERM;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    push_code = OP_NONE;
    item_done = 1'b0;
    ov_nxt    = ov_r;
    cmd_ready = 1'b0;

    unique case (state_r)
      ST_MAIN: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            KIND_DIGIT: begin
              if (can_emit) begin
                emit      = 1'b1;
                emit_char = cmd.ch;
                emit_run  = !cmd.last;
                item_done = 1'b1;
              end
            end
            KIND_LPAREN: begin
              do_push   = 1'b1;
              push_code = OP_LPAREN;
              item_done = 1'b1;
            end
            KIND_OPER: begin
              if (has_top && (top_r != OP_LPAREN) &&
                  (op_prec(top_r) >= op_prec(cmd.code))) begin
                if (can_emit) begin
                  emit      = 1'b1;
                  emit_char = op_char(top_r);
                  emit_run  = !cmd.last && !(below_ok && (below != OP_LPAREN) &&
                              (op_prec(below) >= op_prec(cmd.code)));
                  do_pop    = 1'b1;
                end
              end else begin
                do_push   = 1'b1;
                push_code = cmd.code;
                item_done = 1'b1;
              end
            end
            KIND_RPAREN: begin
              if (!has_top) begin
                item_done = 1'b1;
              end else if (top_r == OP_LPAREN) begin
                do_pop    = 1'b1;
                item_done = 1'b1;
              end else if (can_emit) begin
                emit      = 1'b1;
                emit_char = op_char(top_r);
                emit_run  = !cmd.last && (!below_ok || (below == OP_LPAREN));
                do_pop    = 1'b1;
              end
            end
            default: item_done = 1'b1;
          endcase
          // Finish the request, or go flush at the end of the expression
          if (item_done) begin
            if (cmd.last) begin
              state_nxt = ST_FLUSH;
            end else begin
              cmd_ready = 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          emit = 1'b1;
          if (has_top) begin
            emit_char = op_char(top_r);
            do_pop    = 1'b1;
          end else begin
            emit_char = CH_TERM;
            emit_run  = 1'b1;
            emit_end  = 1'b1;
            ov_nxt    = 1'b0;
            cmd_ready = 1'b1;
            state_nxt = ST_MAIN;
          end
        end
      end
      default: state_nxt = ST_MAIN;
    endcase

    // Apply the stack update; spill the old top into memory on a push
    cnt_nxt = cnt_r;
    top_nxt = top_r;
    we      = 1'b0;
    waddr   = cnt_r - CNT_ONE;
    if (do_pop) begin
      top_nxt = below;
      cnt_nxt = cnt_r - CNT_ONE;
    end else if (do_push) begin
      if (cnt_r < CNT_MAX) begin
        we      = has_top;
        top_nxt = push_code;
        cnt_nxt = cnt_r + CNT_ONE;
      end else begin
        ov_nxt = 1'b1;
      end
    end
    // Prefetch the entry below the next top
    raddr = cnt_nxt - CNT_TWO;
  end

  itp_ram #(
    .WIDTH (3),
    .DEPTH (RAM_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (3'(top_r)),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_MAIN;
      cnt_r       <= '0;
      ov_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    top_r <= top_nxt;
    // Hold the result until taken; the flag reflects drops so far
    if (emit) begin
      out_char_r     <= emit_char;
      out_run_last_r <= emit_run;
      out_expr_end_r <= emit_end;
      out_overflow_r <= ov_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_run_last = out_run_last_r;
  assign out_expr_end = out_expr_end_r;
  assign out_overflow = out_overflow_r;

  `ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > CNT_MAX, "stack count beyond capacity")
  `ASSERT_AT(a_term_empty, clk, rst_n, (emit && emit_end) |-> (cnt_r == '0), "terminator with stacked operators")
  `ASSERT_AT(a_term_clears, clk, rst_n, (emit && emit_end) |=> (!ov_r && (state_r == ST_MAIN)), "state not cleared after terminator")
  `ASSERT_NEVER(a_push_pop, clk, rst_n, do_push && do_pop, "push and pop in one cycle")

endmodule

/* sv/infix_to_postfix_converter.sv */
// Top level of the infix-to-postfix converter.
//
// Characters of an infix expression enter on the in_ channel, one per request, and
// leave in postfix order on the out_ channel. A front stage classifies each character
// and drops ignored ones (unless marked last), a two-entry queue decouples it from the
// stack sequencer, and the sequencer performs one stack action per cycle, an emitting
// action waiting while out_ is held: a digit is emitted, '(' is pushed, and an operator
// first pops and emits each stacked operator of higher or equal precedence above the
// nearest '(' and is then pushed. The last character of an expression then flushes
// the stack, emitting each entry, and emits the zero terminator. The operator stack
// holds STACK_DEPTH-1 entries, with the top in a register and the rest in a RAM
// whose registered read is prefetched, so the one-pop-per-cycle rate (while out_ is not
// stalled) is set by that RAM read port. On an idle path, a digit's result passes the
// front register, a queue slot and the output register before it is presented on out_.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_expr_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_expr_end,
  output logic       out_overflow
);
  import itp_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  itp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .in_expr_last (in_expr_last),
    .cmd          (front_cmd),
    .cmd_valid    (front_valid),
    .cmd_ready    (front_ready)
  );

  itp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cmd   (front_cmd),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_cmd   (queue_cmd),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (queue_cmd),
    .cmd_valid    (queue_valid),
    .cmd_ready    (queue_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .out_expr_end (out_expr_end),
    .out_overflow (out_overflow)
  );

endmodule

/* tb/infix_to_postfix_converter_checker.sv */
// Scoreboard for the infix-to-postfix converter: shunting-yard prediction and result compare.
`timescale 1ns / 100ps

module postfix_stream_checker #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_expr_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       out_run_last,
  input  logic       out_expr_end,
  input  logic       out_overflow,
  output int         mismatches,
  output int         outstanding,
  output int         chars_checked,
  output int         exprs_closed,
  output int         exprs_overflowed
);

  import itp_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       expr_end;
    logic       ovf;
  } postfix_char_t;

  // Expected postfix characters, oldest first
  postfix_char_t postfix_q[$];
  // Characters caused by the request being predicted
  postfix_char_t step_q[$];

  op_code_t    op_stack [STACK_DEPTH];
  int unsigned stack_fill = 0;
  logic        push_dropped = 1'b0;

  postfix_char_t want;
  postfix_char_t got;

  initial begin
    mismatches       = 0;
    outstanding      = 0;
    chars_checked    = 0;
    exprs_closed     = 0;
    exprs_overflowed = 0;
  end

  function automatic int unsigned rank_of(op_code_t c);
    int unsigned r;
    r = 0;
    case (c)
      OP_TIMES, OP_DIVIDE: r = 2;
      OP_PLUS, OP_MINUS:   r = 1;
      default:             r = 0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] glyph_of(op_code_t c);
    logic [7:0] g;
    g = CH_TERM;
    case (c)
      OP_LPAREN: g = CH_LPAREN;
      OP_PLUS:   g = CH_PLUS;
      OP_MINUS:  g = CH_MINUS;
      OP_TIMES:  g = CH_TIMES;
      OP_DIVIDE: g = CH_DIVIDE;
      default:   g = CH_TERM;
    endcase
    return g;
  endfunction

  task automatic emit_char(input logic [7:0] ch, input logic term);
    postfix_char_t r;
    r.ch       = ch;
    r.run_last = 1'b0;
    r.expr_end = term;
    r.ovf      = push_dropped;
    step_q.push_back(r);
  endtask

  // Push onto the operator stack; one slot stays free, so a full stack drops the push
  task automatic push_op(input op_code_t c);
    if (stack_fill < STACK_DEPTH - 1) begin
      op_stack[stack_fill] = c;
      stack_fill++;
    end else begin
      push_dropped = 1'b1;
    end
  endtask

  // Work out every postfix character caused by one accepted request
  task automatic convert_char(input logic [7:0] ch, input logic last);
    op_code_t      code;
    op_code_t      top;
    logic          found;
    postfix_char_t r;
    step_q.delete();
    code = OP_NONE;
    if (ch == CH_PLUS) code = OP_PLUS;
    else if (ch == CH_MINUS) code = OP_MINUS;
    else if (ch == CH_TIMES) code = OP_TIMES;
    else if (ch == CH_DIVIDE) code = OP_DIVIDE;

    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      emit_char(ch, 1'b0);
    end else if (ch == CH_LPAREN) begin
      push_op(OP_LPAREN);
    end else if (code != OP_NONE) begin
      // Pop operators of higher or equal rank, stop at a '('
      while (stack_fill > 0 && op_stack[stack_fill-1] != OP_LPAREN &&
             rank_of(op_stack[stack_fill-1]) >= rank_of(code)) begin
        emit_char(glyph_of(op_stack[stack_fill-1]), 1'b0);
        stack_fill--;
      end
      push_op(code);
    end else if (ch == CH_RPAREN) begin
      // Pop until the matching '(' is dropped or the stack runs dry
      found = 1'b0;
      while (stack_fill > 0 && !found) begin
        top = op_stack[stack_fill-1];
        stack_fill--;
        if (top == OP_LPAREN) found = 1'b1;
        else emit_char(glyph_of(top), 1'b0);
      end
    end

    // Flush the stack and close the expression
    if (last) begin
      while (stack_fill > 0) begin
        emit_char(glyph_of(op_stack[stack_fill-1]), 1'b0);
        stack_fill--;
      end
      emit_char(CH_TERM, 1'b1);
      stack_fill   = 0;
      push_dropped = 1'b0;
    end

    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.run_last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) postfix_q.push_back(step_q[i]);
  endtask

  // Compare results first, then predict: a request never causes a result on its own edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.ch       = out_char;
        got.run_last = out_run_last;
        got.expr_end = out_expr_end;
        got.ovf      = out_overflow;
        chars_checked++;
        if (out_expr_end) begin
          exprs_closed++;
          if (out_overflow) exprs_overflowed++;
        end
        if (postfix_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result char %h run_last %b end %b ovf %b",
                     $time, got.ch, got.run_last, got.expr_end, got.ovf);
        end else begin
          want = postfix_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: want char %h run_last %b end %b ovf %b",
                       $time, want.ch, want.run_last, want.expr_end, want.ovf);
              $display("%0t:           got char %h run_last %b end %b ovf %b",
                       $time, got.ch, got.run_last, got.expr_end, got.ovf);
            end
          end
        end
      end
      if (in_valid && in_ready) convert_char(in_char, in_expr_last);
      outstanding = postfix_q.size();
    end
  end

endmodule

/* tb/infix_to_postfix_converter_tb.sv */
// Testbench top for the infix-to-postfix converter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;

  import itp_pkg::*;

  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int ITEM_TARGET  = 420;
  localparam int CALM_TAIL    = 60;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [7:0] in_char      = 8'h00;
  logic       in_expr_last = 1'b0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [7:0] out_char;
  logic       out_run_last;
  logic       out_expr_end;
  logic       out_overflow;

  int mismatches;
  int outstanding;
  int chars_checked;
  int exprs_closed;
  int exprs_overflowed;

  int   cycles     = 0;
  int   hold_left  = 0;
  int   items_sent = 0;
  logic calm       = 1'b0;
  logic calm_expr  = 1'b0;

  logic [7:0] expr_buf[$];

  infix_to_postfix_converter #(.STACK_DEPTH(DEPTH)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .in_expr_last(in_expr_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .out_run_last(out_run_last),
    .out_expr_end(out_expr_end),
    .out_overflow(out_overflow)
  );

  postfix_stream_checker #(.STACK_DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char         (in_char),
    .in_expr_last    (in_expr_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_run_last    (out_run_last),
    .out_expr_end    (out_expr_end),
    .out_overflow    (out_overflow),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .chars_checked   (chars_checked),
    .exprs_closed    (exprs_closed),
    .exprs_overflowed(exprs_overflowed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (!rst_n || calm || calm_expr) begin
      out_ready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      hold_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic is_token(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_LPAREN || c == CH_RPAREN ||
           c == CH_PLUS || c == CH_MINUS || c == CH_TIMES || c == CH_DIVIDE;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_token(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] pick_op();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = CH_PLUS;
      1:       c = CH_MINUS;
      2:       c = CH_TIMES;
      default: c = CH_DIVIDE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Drive one request and hold it until accepted
  task automatic send_char(input logic [7:0] ch, input logic last);
    if (!calm && !calm_expr && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char      <= ch;
    in_expr_last <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (items_sent >= ITEM_TARGET - CALM_TAIL) calm = 1'b1;
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_buf.size(); i++)
      send_char(expr_buf[i], i == expr_buf.size() - 1);
  endtask

  // Append a symbol, sometimes followed by a character the block ignores
  task automatic add_sym(input logic [7:0] c);
    expr_buf.push_back(c);
    if ($urandom_range(0, 9) == 0) expr_buf.push_back(junk_char());
  endtask

  // Build a balanced expression of ntok operands
  task automatic build_balanced(input int ntok, input int max_nest);
    int nest;
    nest = 0;
    for (int k = 0; k < ntok; k++) begin
      while (nest < max_nest && $urandom_range(0, 3) == 0) begin
        add_sym(CH_LPAREN);
        nest++;
      end
      add_sym(pick_digit());
      while (nest > 0 && $urandom_range(0, 2) == 0) begin
        add_sym(CH_RPAREN);
        nest--;
      end
      if (k < ntok - 1) add_sym(pick_op());
    end
    while (nest > 0) begin
      add_sym(CH_RPAREN);
      nest--;
    end
  endtask

  // Nest deeply, at times enough to fill the stack and drop pushes
  task automatic build_deep();
    int n;
    logic with_ops;
    n = $urandom_range(DEPTH / 2, DEPTH + 3);
    with_ops = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      expr_buf.push_back(CH_LPAREN);
      if (with_ops) begin
        expr_buf.push_back(pick_digit());
        expr_buf.push_back(pick_op());
      end
    end
    expr_buf.push_back(pick_digit());
    repeat ($urandom_range(0, n + 1)) expr_buf.push_back(CH_RPAREN);
  endtask

  // Corrupt a balanced expression: replace, drop or insert a symbol
  task automatic break_expr();
    int i;
    repeat ($urandom_range(1, 2)) begin
      i = $urandom_range(0, expr_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: expr_buf[i] = $urandom_range(0, 1) ? pick_op()
                       : ($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
        1: if (expr_buf.size() > 1) expr_buf.delete(i);
        default: expr_buf.insert(i, $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
      endcase
    end
  endtask

  initial begin
    int pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all operators, equal and higher rank, nesting
    expr_buf = {CH_ZERO, CH_PLUS, CH_NINE, CH_TIMES, CH_LPAREN, 8'h31, CH_MINUS, 8'h32,
                CH_RPAREN, CH_DIVIDE, 8'h33, CH_MINUS, 8'h34};
    send_expr();
    // Directed: ignored extremes, stray ')', unmatched '(' at the end
    expr_buf = {8'hFF, CH_TERM, 8'h35, CH_MINUS, 8'h36, CH_RPAREN, CH_RPAREN,
                CH_LPAREN, CH_LPAREN};
    send_expr();
    // Directed: ignored character marked last
    expr_buf = {8'h3A};
    send_expr();

    // Random expressions, mostly well formed
    while (items_sent < ITEM_TARGET) begin
      expr_buf.delete();
      calm_expr = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        build_deep();
      end else if (pick < 76) begin
        build_balanced($urandom_range(1, 10), $urandom_range(0, 5));
      end else if (pick < 88) begin
        build_balanced($urandom_range(1, 8), 3);
        break_expr();
      end else begin
        repeat ($urandom_range(1, 8)) expr_buf.push_back(8'($urandom_range(0, 255)));
      end
      send_expr();
    end
    in_valid  <= 1'b0;
    calm_expr = 1'b0;

    // Drain outstanding results, then watch for strays
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests; checked %0d postfix characters over %0d expressions.",
             items_sent, chars_checked, exprs_closed);
    $display("%0d expressions overflowed the operator stack; %0d mismatches.",
             exprs_overflowed, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
